// File: hdl/sorted_score_queue_unit_assert.svh
// Assertion macros for the checker file of the sorted score queue.
`ifndef SORTED_SCORE_QUEUE_UNIT_ASSERT_SVH
`define SORTED_SCORE_QUEUE_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define SSQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/ssq_pkg.sv
// Shared operation codes and cell control type for the sorted score queue.
`default_nettype none
package ssq_pkg;

  localparam int ScoreBits = 32;
  localparam int TagFieldBits = 16;
  localparam int CountBits = 5;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpClear  = 2'd2,
    OpNone   = 2'd3
  } ssq_op_e;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;   // insert shift this cycle
    logic rem;   // pop shift this cycle
  } ssq_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/ssq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module ssq_cell
  import ssq_pkg::*;
#(
  parameter int TAG_W = 16
) (
  input  wire logic                        clk_i,
  input  wire ssq_ctrl_t                   ctrl_i,
  input  wire logic                        occ_i,
  input  wire logic signed [ScoreBits-1:0] new_score_i,
  input  wire logic [TAG_W-1:0]            new_tag_i,
  input  wire logic                        left_take_i,
  input  wire logic signed [ScoreBits-1:0] left_score_i,
  input  wire logic [TAG_W-1:0]            left_tag_i,
  input  wire logic signed [ScoreBits-1:0] right_score_i,
  input  wire logic [TAG_W-1:0]            right_tag_i,
  output logic                             take_o,
  output logic signed [ScoreBits-1:0]      score_o,
  output logic [TAG_W-1:0]                 tag_o
);

  logic signed [ScoreBits-1:0] score_q, score_d;
  logic [TAG_W-1:0]            tag_q, tag_d;

  // Free slots and slots ranked below the new score are at or past the insert point.
  assign take_o = !occ_i || (new_score_i > score_q);

  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (ctrl_i.ins) begin
      if (take_o && !left_take_i) begin
        score_d = new_score_i;
        tag_d   = new_tag_i;
      end else if (take_o) begin
        score_d = left_score_i;
        tag_d   = left_tag_i;
      end
    end else if (ctrl_i.rem) begin
      score_d = right_score_i;
      tag_d   = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    tag_q   <= tag_d;
  end

  assign score_o = score_q;
  assign tag_o   = tag_q;

endmodule
`default_nettype wire

// File: hdl/sorted_score_queue_unit.sv
// Top level of the sorted score queue: cell chain, fill count and result register.
//
//  channel   dir  tdata fields (lsb first)                                    width
//  s_axis    in   operation[1:0] new_score[33:2] player_tag[49:34]              56
//  m_axis    out  top_score[31:0] top_tag[47:32] was_empty[48] dropped[49]
//                 entry_count[54:50]                                            56
//
// One request per cycle unless a result is stalled; each cell compares the new
// score in parallel and shifts one slot, so an operation completes in the cycle
// it is accepted. The result lands in an output register in the cycle after the
// request. A stalled result blocks new requests only until it is taken (tready
// passes through combinationally). Reset clears the fill count and the output
// valid; slot contents are not reset.
`default_nettype none
module sorted_score_queue_unit
  import ssq_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // operation[1:0], new_score[33:2], player_tag[49:34], zero pad
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // top_score[31:0], top_tag[47:32], was_empty[48], dropped[49],
  // entry_count[54:50], zero pad
  output logic [55:0]      m_axis_tdata_o
);

  localparam int TagW = (TAG_BITS < TagFieldBits) ? TAG_BITS : TagFieldBits;
  localparam int FillW = $clog2(TABLE_DEPTH + 1);
  localparam logic [FillW-1:0] FullLevel = FillW'(TABLE_DEPTH);

  logic                        fire;
  ssq_op_e                     op;
  logic signed [ScoreBits-1:0] in_score;
  logic [TagW-1:0]             in_tag;
  ssq_ctrl_t                   ctrl;

  logic [FillW-1:0] fill_q, fill_d;
  logic             full, empty;

  logic signed [ScoreBits-1:0] score_w [TABLE_DEPTH];
  logic [TagW-1:0]             tag_w   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      take_w;

  logic        m_valid_q;
  logic [55:0] m_data_q, m_data_d;

  assign op       = ssq_op_e'(s_axis_tdata_i[1:0]);
  assign in_score = $signed(s_axis_tdata_i[33:2]);
  assign in_tag   = s_axis_tdata_i[34 +: TagW];

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign full  = (fill_q == FullLevel);
  assign empty = (fill_q == '0);

  assign ctrl.ins = fire && (op == OpInsert);
  assign ctrl.rem = fire && (op == OpRemove) && !empty;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                        left_take;
    logic signed [ScoreBits-1:0] left_score, right_score;
    logic [TagW-1:0]             left_tag, right_tag;

    if (i == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_score = in_score;
      assign left_tag   = in_tag;
    end else begin : g_mid
      assign left_take  = take_w[i-1];
      assign left_score = score_w[i-1];
      assign left_tag   = tag_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_score = score_w[i];
      assign right_tag   = tag_w[i];
    end else begin : g_inner
      assign right_score = score_w[i+1];
      assign right_tag   = tag_w[i+1];
    end

    ssq_cell #(
      .TAG_W(TagW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (fill_q > FillW'(i)),
      .new_score_i  (in_score),
      .new_tag_i    (in_tag),
      .left_take_i  (left_take),
      .left_score_i (left_score),
      .left_tag_i   (left_tag),
      .right_score_i(right_score),
      .right_tag_i  (right_tag),
      .take_o       (take_w[i]),
      .score_o      (score_w[i]),
      .tag_o        (tag_w[i])
    );
  end

  always_comb begin
    fill_d   = fill_q;
    m_data_d = '0;
    case (op)
      OpInsert: begin
        if (!full) begin
          fill_d = fill_q + FillW'(1);
        end
        m_data_d[49] = full;
      end
      OpRemove: begin
        if (empty) begin
          m_data_d[48] = 1'b1;
        end else begin
          fill_d          = fill_q - FillW'(1);
          m_data_d[31:0]  = score_w[0];
          m_data_d[47:32] = TagFieldBits'(tag_w[0]);
        end
      end
      OpClear: fill_d = '0;
      default: fill_d = fill_q;
    endcase
    m_data_d[54:50] = CountBits'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        fill_q <= fill_d;
      end
      if (s_axis_tready_o) begin
        m_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
`default_nettype wire

// File: hdl/ssq_checker.sv
// Port-level assertions for the sorted score queue, bound to the top level.
`default_nettype none
`include "sorted_score_queue_unit_assert.svh"
module ssq_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [55:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [55:0] m_axis_tdata_o
);

  localparam logic [4:0] FullCount = 5'(TABLE_DEPTH);

  `SSQ_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `SSQ_ASSERT(a_empty_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[48] |-> m_axis_tdata_o[47:0] == 48'd0 && m_axis_tdata_o[54:50] == 5'd0 && !m_axis_tdata_o[49], "empty remove reported data")
  `SSQ_ASSERT(a_drop_full, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[49] |-> m_axis_tdata_o[54:50] == FullCount && m_axis_tdata_o[47:0] == 48'd0, "drop reported without full table")
  `SSQ_ASSERT(a_accept_when_free, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o, "request refused with no pending result")
  `SSQ_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

  logic unused_ok;
  assign unused_ok = s_axis_tvalid_i ^ (^s_axis_tdata_i);

endmodule

bind sorted_score_queue_unit ssq_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_ssq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
`default_nettype wire
